// ===== rtl/core/frd_pkg.sv =====
package frd_pkg;

	// Fixed field widths
	localparam int SAMPLE_W      = 10;
	localparam int FIELD_COUNT   = 5;
	localparam int THRESH_W      = 10;
	localparam int DELAY_W       = 8;
	localparam int MON_W         = 3;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;
	localparam int S_TDATA_W     = 56;
	localparam int M_TDATA_W     = 24;

	// Default build values
	localparam int DEF_SENSOR_COUNT = 5;
	localparam int DEF_GAUSS_LOW    = -1000;
	localparam int DEF_GAUSS_HIGH   = 1000;
	localparam int DEF_SAMPLE_BITS  = 10;

	// Register map, index = byte address / 4
	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_DELAY     = 3'd1;
	localparam logic [2:0] REG_MONITOR   = 3'd2;
	localparam logic [2:0] REG_CHAINED   = 3'd3;
	localparam logic [2:0] REG_LAST      = 3'd4;

	// Register reset values
	localparam logic [THRESH_W-1:0] RST_THRESHOLD = 10'd100;
	localparam logic [DELAY_W-1:0]  RST_DELAY     = 8'd30;
	localparam logic [MON_W-1:0]    RST_MONITOR   = 3'd5;

	// Request kinds on tuser
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef struct packed {
		logic [THRESH_W-1:0] threshold;
		logic [DELAY_W-1:0]  delay;
		logic [MON_W-1:0]    monitor;
		logic                chained;
		logic                last;
	} cfg_t;

	typedef struct packed {
		logic [DELAY_W-1:0]     seconds_left;
		logic                   counting;
		logic                   local_runout;
		logic [FIELD_COUNT-1:0] present_mask;
		logic                   trigger_changed;
		logic                   trigger_out;
	} res_t;

endpackage

// ===== rtl/core/frd_regs.sv =====
module frd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [frd_pkg::ADDR_W-1:0]  paddr,
	input  logic [frd_pkg::DATA_W-1:0]  pwdata,
	output logic [frd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output frd_pkg::cfg_t               cfg
);
	import frd_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[4:2];
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= RST_THRESHOLD;
			cfg_q.delay     <= RST_DELAY;
			cfg_q.monitor   <= RST_MONITOR;
			cfg_q.chained   <= 1'b0;
			cfg_q.last      <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_THRESHOLD: cfg_q.threshold <= pwdata[THRESH_W-1:0];
				REG_DELAY:     cfg_q.delay     <= pwdata[DELAY_W-1:0];
				REG_MONITOR:   cfg_q.monitor   <= pwdata[MON_W-1:0];
				REG_CHAINED:   cfg_q.chained   <= pwdata[0];
				REG_LAST:      cfg_q.last      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_sel)
			REG_THRESHOLD: prdata = DATA_W'(cfg_q.threshold);
			REG_DELAY:     prdata = DATA_W'(cfg_q.delay);
			REG_MONITOR:   prdata = DATA_W'(cfg_q.monitor);
			REG_CHAINED:   prdata = DATA_W'(cfg_q.chained);
			REG_LAST:      prdata = DATA_W'(cfg_q.last);
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/frd_sense.sv =====
module frd_sense #(
	parameter int SENSOR_COUNT = frd_pkg::DEF_SENSOR_COUNT,
	parameter int GAUSS_LOW    = frd_pkg::DEF_GAUSS_LOW,
	parameter int GAUSS_HIGH   = frd_pkg::DEF_GAUSS_HIGH,
	parameter int SAMPLE_BITS  = frd_pkg::DEF_SAMPLE_BITS
) (
	input  logic [frd_pkg::FIELD_COUNT-1:0][frd_pkg::SAMPLE_W-1:0] samples,
	input  logic [frd_pkg::THRESH_W-1:0]                           threshold,
	output logic [frd_pkg::FIELD_COUNT-1:0]                        mask
);
	import frd_pkg::*;

	// gauss = floor(val*SPAN/FULL) + GAUSS_LOW; present when 4*gauss >= 7*T.
	// That is floor(val*SPAN/FULL) >= K with K = ceil((7T - 4*GAUSS_LOW)/4),
	// which equals val*SPAN >= K*FULL, so no divider is needed.
	localparam int EVAL    = (SENSOR_COUNT < FIELD_COUNT) ? SENSOR_COUNT : FIELD_COUNT;
	localparam int SPAN    = GAUSS_HIGH - GAUSS_LOW;
	localparam int FULL    = (1 << SAMPLE_BITS) - 1;
	localparam int LOW_OFS = -4 * GAUSS_LOW;
	localparam int ADJ_W   = 15;
	localparam int K_W     = ADJ_W - 2;
	localparam int PROD_W  = SAMPLE_BITS + 14;

	logic [ADJ_W-1:0]  adj;
	logic [K_W-1:0]    k_min;
	logic [PROD_W-1:0] limit;

	// Threshold in product units, shared by all sensors
	assign adj   = ({(ADJ_W-THRESH_W)'(0), threshold} * ADJ_W'(7)) + ADJ_W'(LOW_OFS + 3);
	assign k_min = adj[ADJ_W-1:2];
	assign limit = PROD_W'(k_min) * PROD_W'(FULL);

	// Per-sensor compare
	for (genvar i = 0; i < FIELD_COUNT; i++) begin : g_sensor
		if (i < EVAL) begin : g_eval
			logic [SAMPLE_W+SAMPLE_BITS-1:0] raw_ext;
			logic [SAMPLE_BITS-1:0]          val;
			logic [PROD_W-1:0]               prod;

			assign raw_ext = {{SAMPLE_BITS{1'b0}}, samples[i]};
			assign val     = raw_ext[SAMPLE_BITS-1:0] & ~SAMPLE_BITS'(7);
			assign prod    = PROD_W'(val) * PROD_W'(SPAN);
			assign mask[i] = (prod >= limit);
		end else begin : g_off
			assign mask[i] = 1'b0;
		end
	end

endmodule

// ===== rtl/core/frd_core.sv =====
module frd_core #(
	parameter int SENSOR_COUNT = frd_pkg::DEF_SENSOR_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic                            req_type,
	input  logic                            chain_in,
	input  logic [frd_pkg::FIELD_COUNT-1:0] mask_in,
	input  frd_pkg::cfg_t                   cfg,
	input  logic                            res_valid,
	output frd_pkg::res_t                   res
);
	import frd_pkg::*;

	localparam int EVAL = (SENSOR_COUNT < FIELD_COUNT) ? SENSOR_COUNT : FIELD_COUNT;
	localparam logic [FIELD_COUNT-1:0] FULL_MASK = FIELD_COUNT'((1 << EVAL) - 1);

	logic [DELAY_W-1:0]     elapsed_q, elapsed_d;
	logic                   active_q, active_d;
	logic                   chained_q, chained_d;
	logic                   trig_q, trig_d;
	logic [FIELD_COUNT-1:0] mask_q, mask_d;
	res_t                   res_q;
	logic                   runout;
	logic [DELAY_W-1:0]     elapsed_inc;

	assign elapsed_inc = (elapsed_q == {DELAY_W{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;

	// Runout on the monitored sensor, or on all sensors
	always_comb begin
		if ({1'b0, cfg.monitor} < (MON_W+1)'(EVAL))
			runout = !mask_in[cfg.monitor];
		else
			runout = (mask_in == '0);
	end

	// Next state
	always_comb begin
		elapsed_d = elapsed_q;
		active_d  = active_q;
		chained_d = chained_q;
		trig_d    = trig_q;
		mask_d    = mask_q;
		if (req_type == REQ_TICK) begin
			if (active_q) begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= cfg.delay)
					trig_d = 1'b1;
			end
		end else begin
			mask_d = mask_in;
			if (!runout) begin
				trig_d    = 1'b0;
				chained_d = 1'b0;
				active_d  = 1'b0;
				elapsed_d = '0;
			end else if (cfg.chained && !cfg.last) begin
				chained_d = 1'b1;
				active_d  = 1'b0;
				elapsed_d = '0;
				trig_d    = chain_in;
			end else begin
				if (!active_q) begin
					active_d  = 1'b1;
					elapsed_d = '0;
				end
				if (elapsed_d >= cfg.delay)
					trig_d = 1'b1;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			active_q  <= 1'b0;
			chained_q <= 1'b0;
			trig_q    <= 1'b0;
			mask_q    <= FULL_MASK;
		end else if (load) begin
			elapsed_q <= elapsed_d;
			active_q  <= active_d;
			chained_q <= chained_d;
			trig_q    <= trig_d;
			mask_q    <= mask_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.trigger_out     <= trig_d;
			res_q.trigger_changed <= trig_d != trig_q;
			res_q.present_mask    <= mask_d;
			res_q.local_runout    <= chained_d;
			res_q.counting        <= active_d;
			res_q.seconds_left    <= (active_d && cfg.delay > elapsed_d) ?
				cfg.delay - elapsed_d : '0;
		end
	end

	assign res = res_q;

	// Elapsed time only runs while the countdown is active
	a_elapsed_active: assert property (@(posedge clk) disable iff (!arst_n)
		elapsed_q != '0 |-> active_q)
		else $error("elapsed seconds set without active countdown");

	// Delivered level matches the stored level
	a_trig_track: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_q.trigger_out == trig_q)
		else $error("result trigger differs from state");

	// Remaining time only shows while counting
	a_left_counting: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_q.seconds_left != '0 |-> res_q.counting)
		else $error("seconds left without countdown");

	// Unevaluated sensors never report present
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q & ~FULL_MASK) == '0)
		else $error("mask bit set for unevaluated sensor");

endmodule

// ===== rtl/core/filament_runout_detector.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: sample_0..4, chain_in
// m_*       out  m_tvalid/m_tready  tdata: trigger, changed, mask, local, counting, left
// apb       in   psel/penable       five config registers at 4*i, pready tied high
//
// One item per cycle sustained while the output is not stalled.
// An input register and a result register bracket the sensor compare and
// countdown logic; the state updates when an item moves into the result register.
// A stalled output holds its result; one more request is held in the input stage.
// Reset clears the countdown and trigger and marks every evaluated sensor present.
module filament_runout_detector #(
	parameter int SENSOR_COUNT = frd_pkg::DEF_SENSOR_COUNT,
	parameter int GAUSS_LOW    = frd_pkg::DEF_GAUSS_LOW,
	parameter int GAUSS_HIGH   = frd_pkg::DEF_GAUSS_HIGH,
	parameter int SAMPLE_BITS  = frd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [9:0] sample_0, [19:10] sample_1, [29:20] sample_2, [39:30] sample_3,
	// [49:40] sample_4, [50] chain_in, [55:51] zero
	input  logic [frd_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] req_type
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] trigger_out, [1] trigger_changed, [6:2] present_mask,
	// [7] local_runout, [8] counting, [16:9] seconds_left, [23:17] zero
	output logic [frd_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [frd_pkg::ADDR_W-1:0]     paddr,
	input  logic [frd_pkg::DATA_W-1:0]     pwdata,
	output logic [frd_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import frd_pkg::*;

	localparam int CHAIN_BIT = FIELD_COUNT * SAMPLE_W;

	cfg_t                                    cfg;
	res_t                                    res;
	logic                                    valid_s1;
	logic                                    type_s1;
	logic                                    chain_s1;
	logic [FIELD_COUNT-1:0][SAMPLE_W-1:0]    samples_s1;
	logic                                    out_valid_q;
	logic                                    advance;
	logic [FIELD_COUNT-1:0]                  mask;

	frd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Move the held request on when the result slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			type_s1    <= s_tuser[0];
			chain_s1   <= s_tdata[CHAIN_BIT];
			samples_s1 <= s_tdata[CHAIN_BIT-1:0];
		end
	end

	frd_sense #(
		.SENSOR_COUNT (SENSOR_COUNT),
		.GAUSS_LOW    (GAUSS_LOW),
		.GAUSS_HIGH   (GAUSS_HIGH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_sense (
		.samples   (samples_s1),
		.threshold (cfg.threshold),
		.mask      (mask)
	);

	frd_core #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.req_type  (type_s1),
		.chain_in  (chain_s1),
		.mask_in   (mask),
		.cfg       (cfg),
		.res_valid (out_valid_q),
		.res       (res)
	);

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(res);

endmodule
